@@ sv/acbd_pkg.sv @@
// ----------------------------------------------------------------------------
// acbd_pkg: shared types and constants
// Types, codes and helpers used by the block arithmetic decoder modules.
// ----------------------------------------------------------------------------
package acbd_pkg;

    localparam int FRAC_W  = 64;
    localparam int CUM_W   = 32;
    localparam int SYM_W   = 8;
    localparam int SPB_W   = 7;
    localparam int BYTE_W  = 8;

    // Request kinds on the input stream.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CODE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_TOTAL = 1'b0;
    localparam logic CFG_SPB   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYM,
        ST_SCAN,
        ST_READ,
        ST_LO,
        ST_HI,
        ST_EMIT
    } acbd_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_ADD,
        B_CHECK,
        B_DIV,
        B_DONE
    } bnd_state_t;

    typedef struct packed {
        logic               start;
        logic               full;
        logic [CUM_W-1:0]   cum;
        logic [FRAC_W-1:0]  low;
        logic [FRAC_W-1:0]  span;
    } bnd_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               one;
        logic [FRAC_W-1:0]  v;
    } bnd_resp_t;

    function automatic logic [FRAC_W-1:0] frac_mask(input int frac_bits);
        logic [FRAC_W-1:0] m;
        m = '1;
        return m << (FRAC_W - frac_bits);
    endfunction

endpackage

@@ sv/acbd_table.sv @@
// ----------------------------------------------------------------------------
// acbd_table: cumulative range table
// Memory of low/high cumulative counts per symbol, with reset-cleared valid bits.
// ----------------------------------------------------------------------------
module acbd_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int IDX_W       = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic [acbd_pkg::CUM_W-1:0] wr_low,
    input  logic [acbd_pkg::CUM_W-1:0] wr_high,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic [acbd_pkg::CUM_W-1:0] rd_low,
    output logic [acbd_pkg::CUM_W-1:0] rd_high,
    output logic                      rd_valid
);

    logic [2*acbd_pkg::CUM_W-1:0] mem [TABLE_DEPTH];
    logic [2*acbd_pkg::CUM_W-1:0] rd_data_reg;
    logic [TABLE_DEPTH-1:0]       valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_high, wr_low};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_low   = rd_data_reg[acbd_pkg::CUM_W-1:0];
    assign rd_high  = rd_data_reg[2*acbd_pkg::CUM_W-1:acbd_pkg::CUM_W];
    assign rd_valid = valid_reg[rd_addr];

endmodule

@@ sv/acbd_bound.sv @@
// ----------------------------------------------------------------------------
// acbd_bound: interval bound unit
// Computes low + floor(cum*span/total) from 32x32 products of the span halves (none
// for a full span) and a bit-serial restoring divider; saturates to one.
// ----------------------------------------------------------------------------
module acbd_bound #(
    parameter int FRACTION_BITS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  acbd_pkg::bnd_req_t         req,
    input  logic [acbd_pkg::CUM_W-1:0] divisor,
    output acbd_pkg::bnd_resp_t        resp
);

    localparam int FW = acbd_pkg::FRAC_W;
    localparam int CW = acbd_pkg::CUM_W;
    localparam int PW = FW + CW;

    acbd_pkg::bnd_state_t state_reg, state_next;

    logic [FW-1:0]   low_reg;
    logic [FW-1:0]   span_reg;
    logic [CW-1:0]   cum_reg;
    logic [CW-1:0]   div_reg;
    logic [2*CW-1:0] m_reg;
    logic [PW-1:0]   p_reg;
    logic [CW-1:0]   rem_reg;
    logic [FW-1:0]   quo_reg;
    logic [5:0]      cnt_reg;
    logic            ovf_reg;

    logic [CW:0]     rem_shift;
    logic            rem_ge;
    logic [FW:0]     sum;

    assign rem_shift = {rem_reg, quo_reg[FW-1]};
    assign rem_ge    = rem_shift >= {1'b0, div_reg};
    assign sum       = {1'b0, low_reg} + {1'b0, quo_reg & acbd_pkg::frac_mask(FRACTION_BITS)};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            acbd_pkg::B_IDLE:
            begin
                if (req.start)
                begin
                    state_next = req.full ? acbd_pkg::B_CHECK : acbd_pkg::B_MUL_LO;
                end
            end
            acbd_pkg::B_MUL_LO: state_next = acbd_pkg::B_MUL_HI;
            acbd_pkg::B_MUL_HI: state_next = acbd_pkg::B_ADD;
            acbd_pkg::B_ADD:    state_next = acbd_pkg::B_CHECK;
            acbd_pkg::B_CHECK:
            begin
                state_next = (p_reg[PW-1:FW] >= div_reg) ? acbd_pkg::B_DONE : acbd_pkg::B_DIV;
            end
            acbd_pkg::B_DIV:
            begin
                if (cnt_reg == 6'd63)
                begin
                    state_next = acbd_pkg::B_DONE;
                end
            end
            acbd_pkg::B_DONE:
            begin
                if (req.start)
                begin
                    state_next = req.full ? acbd_pkg::B_CHECK : acbd_pkg::B_MUL_LO;
                end
                else
                begin
                    state_next = acbd_pkg::B_IDLE;
                end
            end
            default:            state_next = acbd_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acbd_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            acbd_pkg::B_IDLE, acbd_pkg::B_DONE:
            begin
                low_reg  <= req.low;
                span_reg <= req.span;
                cum_reg  <= req.cum;
                div_reg  <= divisor;
                p_reg    <= {req.cum, {FW{1'b0}}};
            end
            acbd_pkg::B_MUL_LO:
            begin
                m_reg <= 64'(span_reg[CW-1:0]) * 64'(cum_reg);
            end
            acbd_pkg::B_MUL_HI:
            begin
                p_reg <= {{CW{1'b0}}, m_reg};
                m_reg <= 64'(span_reg[FW-1:CW]) * 64'(cum_reg);
            end
            acbd_pkg::B_ADD:
            begin
                p_reg <= p_reg + {m_reg, {CW{1'b0}}};
            end
            acbd_pkg::B_CHECK:
            begin
                ovf_reg <= p_reg[PW-1:FW] >= div_reg;
                rem_reg <= p_reg[PW-1:FW];
                quo_reg <= p_reg[FW-1:0];
                cnt_reg <= 6'd0;
            end
            acbd_pkg::B_DIV:
            begin
                rem_reg <= rem_ge ? CW'(rem_shift - {1'b0, div_reg}) : rem_shift[CW-1:0];
                quo_reg <= {quo_reg[FW-2:0], rem_ge};
                cnt_reg <= cnt_reg + 6'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign resp.busy = state_reg != acbd_pkg::B_IDLE;
    assign resp.done = state_reg == acbd_pkg::B_DONE;
    assign resp.one  = ovf_reg | sum[FW];
    assign resp.v    = sum[FW-1:0];

endmodule

@@ sv/arithmetic_code_block_decoder_top.sv @@
// ----------------------------------------------------------------------------
// arithmetic_code_block_decoder_top: block arithmetic decoder
// Loads a symbol frequency table and decodes symbols from fixed-point code
// blocks by repeated interval narrowing.
//
//   Channel | Direction | Transfer contents
//   in      | slave     | tuser req_type; tdata symbol_in, frequency, code_block
//   out     | master    | tdata symbol_out; tuser no_match, finished; tlast last
//   cfg     | write     | cfg_index selects total_symbols or symbols_per_block
//
// Each decoded symbol scans the table in symbol order: an empty entry is
// skipped, and a filled one has its lower bound computed by the bound unit,
// and its upper bound too when that lower bound passes.
// The input is not ready until a code block is done. A finished result
// waits in the output register; the scan stalls only when a new result is
// ready and that register is still full. Reset is asynchronous and clears
// the table valid bits at once.
// ----------------------------------------------------------------------------
module arithmetic_code_block_decoder_top #(
    parameter int TABLE_DEPTH   = 256,
    parameter int CODE_BYTES    = 7,
    parameter int FRACTION_BITS = 64,
    parameter int MAX_BLOCK     = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_tvalid,
    output logic                               in_tready,
    // symbol_in, frequency, code_block
    input  logic [40+CODE_BYTES*acbd_pkg::BYTE_W-1:0] in_tdata,
    // req_type
    input  logic                               in_tuser,
    output logic                               out_tvalid,
    input  logic                               out_tready,
    // symbol_out
    output logic [acbd_pkg::SYM_W-1:0]         out_tdata,
    // no_match, finished
    output logic [1:0]                         out_tuser,
    output logic                               out_tlast,
    input  logic                               cfg_wen,
    input  logic                               cfg_index,
    input  logic [acbd_pkg::CUM_W-1:0]         cfg_wdata
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CODE_W = CODE_BYTES * acbd_pkg::BYTE_W;
    localparam int FW     = acbd_pkg::FRAC_W;
    localparam int CW     = acbd_pkg::CUM_W;
    localparam int NW     = acbd_pkg::SPB_W;

    acbd_pkg::acbd_state_t state_reg, state_next;

    logic [CW-1:0]    total_reg;
    logic [NW-1:0]    spb_reg;
    logic [CW-1:0]    remaining_reg;
    logic [CW-1:0]    running_reg;
    logic [NW-1:0]    limit_reg;
    logic [NW-1:0]    n_reg;
    logic [FW-1:0]    num_reg;
    logic [IDX_W-1:0] s_reg;
    logic [FW-1:0]    low_reg;
    logic [FW-1:0]    span_reg;
    logic             full_reg;
    logic [FW-1:0]    lo_v_reg;
    logic [7:0]       res_sym_reg;
    logic             res_hit_reg;
    logic             out_valid_reg;
    logic [7:0]       out_sym_reg;
    logic             out_nm_reg;
    logic             out_last_reg;
    logic             out_fin_reg;

    logic [7:0]       in_sym;
    logic [CW-1:0]    in_freq;
    logic [CODE_W-1:0] in_code;
    logic             accept;
    logic             load_ok;
    logic [CW:0]      cum_sum;
    logic [CW-1:0]    cum_hi;
    logic [FW-1:0]    code_frac;
    logic [NW-1:0]    limit_in;
    logic             rd_en;
    logic [CW-1:0]    rd_low;
    logic [CW-1:0]    rd_high;
    logic             rd_valid;
    logic             emit;
    logic             last_now;
    logic             lo_ok;
    logic             hi_ok;
    logic             s_end;
    logic [CW-1:0]    divisor;

    acbd_pkg::bnd_req_t  bnd_req;
    acbd_pkg::bnd_resp_t bnd_resp;

    assign in_sym  = in_tdata[7:0];
    assign in_freq = in_tdata[39:8];
    assign in_code = in_tdata[40+CODE_W-1:40];
    assign accept  = in_tvalid && in_tready;
    assign load_ok = {1'b0, in_sym} < 9'(TABLE_DEPTH);
    assign cum_sum = {1'b0, running_reg} + {1'b0, in_freq};
    assign cum_hi  = cum_sum[CW] ? '1 : cum_sum[CW-1:0];
    assign limit_in = (spb_reg > NW'(MAX_BLOCK)) ? NW'(MAX_BLOCK) : spb_reg;
    assign divisor = (total_reg == '0) ? CW'(1) : total_reg;

    always_comb
    begin
        code_frac = '0;
        for (int k = 0; k < FW; k++)
        begin
            if (k < CODE_W)
            begin
                code_frac[FW-1-k] = in_code[k];
            end
        end
        code_frac = code_frac & acbd_pkg::frac_mask(FRACTION_BITS);
    end

    acbd_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && in_tuser == acbd_pkg::REQ_LOAD && load_ok),
        .wr_addr  (in_sym[IDX_W-1:0]),
        .wr_low   (running_reg),
        .wr_high  (cum_hi),
        .rd_en    (rd_en),
        .rd_addr  (s_reg),
        .rd_low   (rd_low),
        .rd_high  (rd_high),
        .rd_valid (rd_valid)
    );

    acbd_bound #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_bound (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (bnd_req),
        .divisor (divisor),
        .resp    (bnd_resp)
    );

    assign lo_ok    = !bnd_resp.one && bnd_resp.v <= num_reg;
    assign hi_ok    = bnd_resp.one || num_reg < bnd_resp.v;
    assign s_end    = s_reg == IDX_W'(TABLE_DEPTH - 1);
    assign last_now = (n_reg + NW'(1) == limit_reg) || (remaining_reg == CW'(1));

    always_comb
    begin
        state_next    = state_reg;
        in_tready     = 1'b0;
        rd_en         = 1'b0;
        emit          = 1'b0;
        bnd_req.start = 1'b0;
        bnd_req.full  = full_reg;
        bnd_req.low   = low_reg;
        bnd_req.span  = span_reg;
        bnd_req.cum   = (state_reg == acbd_pkg::ST_READ) ? rd_low : rd_high;
        case (state_reg)
            acbd_pkg::ST_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid && in_tuser == acbd_pkg::REQ_CODE && limit_in != '0
                    && remaining_reg != '0)
                begin
                    state_next = acbd_pkg::ST_SYM;
                end
            end
            acbd_pkg::ST_SYM:
            begin
                state_next = acbd_pkg::ST_SCAN;
            end
            acbd_pkg::ST_SCAN:
            begin
                if (rd_valid)
                begin
                    rd_en      = 1'b1;
                    state_next = acbd_pkg::ST_READ;
                end
                else if (s_end)
                begin
                    state_next = acbd_pkg::ST_EMIT;
                end
            end
            acbd_pkg::ST_READ:
            begin
                bnd_req.start = 1'b1;
                state_next    = acbd_pkg::ST_LO;
            end
            acbd_pkg::ST_LO:
            begin
                if (bnd_resp.done)
                begin
                    if (lo_ok)
                    begin
                        bnd_req.start = 1'b1;
                        state_next    = acbd_pkg::ST_HI;
                    end
                    else
                    begin
                        state_next = s_end ? acbd_pkg::ST_EMIT : acbd_pkg::ST_SCAN;
                    end
                end
            end
            acbd_pkg::ST_HI:
            begin
                if (bnd_resp.done)
                begin
                    state_next = (hi_ok || s_end) ? acbd_pkg::ST_EMIT : acbd_pkg::ST_SCAN;
                end
            end
            acbd_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_tready)
                begin
                    emit       = 1'b1;
                    state_next = last_now ? acbd_pkg::ST_IDLE : acbd_pkg::ST_SYM;
                end
            end
            default:
            begin
                state_next = acbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acbd_pkg::ST_IDLE;
            total_reg     <= CW'(1);
            spb_reg       <= NW'(8);
            remaining_reg <= CW'(1);
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen && cfg_index == acbd_pkg::CFG_TOTAL)
            begin
                total_reg     <= cfg_wdata;
                remaining_reg <= cfg_wdata;
            end
            else if (emit)
            begin
                remaining_reg <= remaining_reg - CW'(1);
            end
            if (cfg_wen && cfg_index == acbd_pkg::CFG_SPB)
            begin
                spb_reg <= cfg_wdata[NW-1:0];
            end
            if (accept && in_tuser == acbd_pkg::REQ_LOAD && load_ok)
            begin
                running_reg <= cum_hi;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            limit_reg <= limit_in;
            n_reg     <= '0;
            num_reg   <= code_frac;
            low_reg   <= '0;
            span_reg  <= '0;
            full_reg  <= 1'b1;
        end
        case (state_reg)
            acbd_pkg::ST_SYM:
            begin
                s_reg       <= '0;
                res_sym_reg <= '0;
                res_hit_reg <= 1'b0;
            end
            acbd_pkg::ST_SCAN:
            begin
                if (!rd_valid && !s_end)
                begin
                    s_reg <= s_reg + IDX_W'(1);
                end
            end
            acbd_pkg::ST_LO:
            begin
                if (bnd_resp.done)
                begin
                    lo_v_reg <= bnd_resp.v;
                    if (!lo_ok && !s_end)
                    begin
                        s_reg <= s_reg + IDX_W'(1);
                    end
                end
            end
            acbd_pkg::ST_HI:
            begin
                if (bnd_resp.done)
                begin
                    if (hi_ok)
                    begin
                        low_reg     <= lo_v_reg;
                        res_sym_reg <= 8'(s_reg);
                        res_hit_reg <= 1'b1;
                        if (bnd_resp.one)
                        begin
                            full_reg <= lo_v_reg == '0;
                            span_reg <= FW'(0) - lo_v_reg;
                        end
                        else
                        begin
                            full_reg <= 1'b0;
                            span_reg <= bnd_resp.v - lo_v_reg;
                        end
                    end
                    else if (!s_end)
                    begin
                        s_reg <= s_reg + IDX_W'(1);
                    end
                end
            end
            acbd_pkg::ST_EMIT:
            begin
                if (emit)
                begin
                    n_reg        <= n_reg + NW'(1);
                    out_sym_reg  <= res_sym_reg;
                    out_nm_reg   <= !res_hit_reg;
                    out_last_reg <= last_now;
                    out_fin_reg  <= remaining_reg == CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_sym_reg;
    assign out_tuser  = {out_fin_reg, out_nm_reg};
    assign out_tlast  = out_last_reg;

    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == acbd_pkg::ST_IDLE |-> !bnd_resp.busy)
        else $error("bound unit busy while decoder idle");

    a_sym_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == acbd_pkg::ST_SYM |-> (remaining_reg != '0 && n_reg < limit_reg))
        else $error("symbol started with no work left");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != acbd_pkg::ST_IDLE |-> n_reg <= limit_reg)
        else $error("symbol count exceeded block limit");

    a_emit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted result not held in output register");

endmodule
